// ===== rtl/matrix3_inverse_assert.svh =====
// ---------------------------------------------------------------------------
// matrix3_inverse assertion macros
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define M3I_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The condition must never be true outside reset.
`define M3I_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define M3I_ASSERT(lbl, prop, msg)
`define M3I_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/m3inv_pkg.sv =====
// ---------------------------------------------------------------------------
// m3inv_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package m3inv_pkg;

    // Quotient bits produced by the divider, one per pipeline stage.
    localparam int DIV_STEPS = 32;
    // Cycles from an accepted beat to its result strobe.
    localparam int LATENCY   = 4 + DIV_STEPS + 2;

    // One input beat: three columns in Q4.12.
    typedef struct packed {
        logic signed [15:0] in_c0_x;
        logic signed [15:0] in_c0_y;
        logic signed [15:0] in_c0_z;
        logic signed [15:0] in_c1_x;
        logic signed [15:0] in_c1_y;
        logic signed [15:0] in_c1_z;
        logic signed [15:0] in_c2_x;
        logic signed [15:0] in_c2_y;
        logic signed [15:0] in_c2_z;
    } mat_t;

    // One result beat: inverse columns in Q16.16 and the singular flag.
    typedef struct packed {
        logic signed [31:0] out_c0_x;
        logic signed [31:0] out_c0_y;
        logic signed [31:0] out_c0_z;
        logic signed [31:0] out_c1_x;
        logic signed [31:0] out_c1_y;
        logic signed [31:0] out_c1_z;
        logic signed [31:0] out_c2_x;
        logic signed [31:0] out_c2_y;
        logic signed [31:0] out_c2_z;
        logic               singular;
    } inv_t;

    // Divider lane input: magnitudes and sign of the quotient.
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic        neg;
        logic [31:0] num;
        logic [49:0] den;
    } div_in_t;

    // Divider lane output.
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic [31:0] value;
    } div_out_t;

    // Payload of one divider pipeline stage.
    typedef struct packed {
        logic        zero;
        logic        neg;
        logic        ovf;
        logic [49:0] den;
        logic [59:0] rem;
        logic [31:0] q;
    } div_stage_t;

endpackage
`default_nettype wire

// ===== rtl/m3inv_div.sv =====
// ---------------------------------------------------------------------------
// m3inv_div
// Pipelined restoring divider lane: rounded, saturated Q16.16 quotient.
// ---------------------------------------------------------------------------
`default_nettype none
module m3inv_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire m3inv_pkg::div_in_t  din,
    output m3inv_pkg::div_out_t      dout
);

    localparam int STEPS = m3inv_pkg::DIV_STEPS;

    logic                  valid_reg [0:STEPS];
    m3inv_pkg::div_stage_t st_reg    [0:STEPS];
    m3inv_pkg::div_stage_t st_next   [0:STEPS];
    m3inv_pkg::div_out_t   dout_reg;
    m3inv_pkg::div_out_t   dout_next;
    logic [59:0]           nsum;

    // Scale the numerator, add half the divisor for rounding, check overflow.
    always_comb
    begin
        nsum           = {din.num, 28'd0} + 60'(din.den >> 1);
        st_next[0].zero = din.zero;
        st_next[0].neg  = din.neg;
        st_next[0].den  = din.den;
        st_next[0].rem  = nsum;
        st_next[0].q    = '0;
        st_next[0].ovf  = {22'd0, nsum} >= {din.den, 32'd0};
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam int B = STEPS - 1 - s;
        logic [59:0] shifted;
        always_comb
        begin
            st_next[s + 1] = st_reg[s];
            shifted        = st_reg[s].rem >> B;
            if (shifted >= {10'd0, st_reg[s].den})
            begin
                st_next[s + 1].rem  = st_reg[s].rem - ({10'd0, st_reg[s].den} << B);
                st_next[s + 1].q[B] = 1'b1;
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= din.valid;
            for (int i = 1; i <= STEPS; i++)
            begin
                valid_reg[i] <= valid_reg[i - 1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= STEPS; i++)
        begin
            st_reg[i] <= st_next[i];
        end
    end

    // Apply the sign and saturate.
    always_comb
    begin
        dout_next.valid = valid_reg[STEPS];
        dout_next.zero  = st_reg[STEPS].zero;
        if (st_reg[STEPS].zero)
        begin
            dout_next.value = '0;
        end
        else if (st_reg[STEPS].neg)
        begin
            if (st_reg[STEPS].ovf || (st_reg[STEPS].q > 32'h8000_0000))
            begin
                dout_next.value = 32'h8000_0000;
            end
            else
            begin
                dout_next.value = -st_reg[STEPS].q;
            end
        end
        else
        begin
            if (st_reg[STEPS].ovf || st_reg[STEPS].q[31])
            begin
                dout_next.value = 32'h7FFF_FFFF;
            end
            else
            begin
                dout_next.value = st_reg[STEPS].q;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule
`default_nettype wire

// ===== rtl/matrix3_inverse.sv =====
// ---------------------------------------------------------------------------
// matrix3_inverse
// Streaming 3x3 matrix inverse by the adjugate, Q4.12 in, Q16.16 out.
// ---------------------------------------------------------------------------
// Usage:
//   A beat is taken at a rising edge with start high; busy is always low,
//   so a new matrix may be offered in every cycle.
//   mat carries the three columns a, b, c. The result appears on inv with
//   done high for exactly one cycle. Throughput is one matrix per cycle.
//   The pipeline has 38 register stages: four for the cross products
//   and determinant, a rounding and overflow stage, 32 restoring divider
//   stages (one quotient bit each) and the sign and saturation output stage.
//   A singular matrix gives singular high and all elements zero.
//   Reset clears every valid bit; beats in flight are dropped.
//   The receiver cannot stall: each result must be taken when done is high.
// ---------------------------------------------------------------------------
`default_nettype none
module matrix3_inverse (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire m3inv_pkg::mat_t mat,
    output logic                 done,
    output m3inv_pkg::inv_t      inv
);

    localparam int LAT = m3inv_pkg::LATENCY;

    logic signed [15:0] col [3][3];

    logic               v_reg    [4];
    logic signed [31:0] p_reg    [3][3][2];
    logic signed [31:0] p_next   [3][3][2];
    logic signed [15:0] a1_reg   [3];
    logic signed [15:0] a2_reg   [3];
    logic signed [32:0] cof2_reg [3][3];
    logic signed [32:0] cof3_reg [3][3];
    logic signed [32:0] cof4_reg [3][3];
    logic signed [48:0] dp_reg   [3];
    logic signed [50:0] det_reg;
    logic signed [50:0] det_mag;

    m3inv_pkg::div_in_t  lane_in  [9];
    m3inv_pkg::div_out_t lane_out [9];

    assign busy = 1'b0;

    // Columns as arrays for indexed products.
    assign col[0][0] = mat.in_c0_x;
    assign col[0][1] = mat.in_c0_y;
    assign col[0][2] = mat.in_c0_z;
    assign col[1][0] = mat.in_c1_x;
    assign col[1][1] = mat.in_c1_y;
    assign col[1][2] = mat.in_c1_z;
    assign col[2][0] = mat.in_c2_x;
    assign col[2][1] = mat.in_c2_y;
    assign col[2][2] = mat.in_c2_z;

    // Cross product terms: row r is col[r+1] x col[r+2].
    for (genvar r = 0; r < 3; r++) begin : g_row
        localparam int UR = (r + 1) % 3;
        localparam int VR = (r + 2) % 3;
        for (genvar k = 0; k < 3; k++) begin : g_comp
            localparam int K1 = (k + 1) % 3;
            localparam int K2 = (k + 2) % 3;
            assign p_next[r][k][0] = col[UR][K1] * col[VR][K2];
            assign p_next[r][k][1] = col[UR][K2] * col[VR][K1];
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= start && !busy;
            for (int i = 1; i < 4; i++)
            begin
                v_reg[i] <= v_reg[i - 1];
            end
        end
    end

    // Products, cofactors, determinant terms and determinant.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            a1_reg[r] <= col[0][r];
            a2_reg[r] <= a1_reg[r];
            dp_reg[r] <= a2_reg[r] * cof2_reg[0][r];
            for (int k = 0; k < 3; k++)
            begin
                p_reg[r][k][0] <= p_next[r][k][0];
                p_reg[r][k][1] <= p_next[r][k][1];
                cof2_reg[r][k] <= 33'(p_reg[r][k][0]) - 33'(p_reg[r][k][1]);
                cof3_reg[r][k] <= cof2_reg[r][k];
                cof4_reg[r][k] <= cof3_reg[r][k];
            end
        end
        det_reg <= 51'(dp_reg[0]) + 51'(dp_reg[1]) + 51'(dp_reg[2]);
    end

    assign det_mag = det_reg[50] ? -det_reg : det_reg;

    // Divider lanes: lane k*3+j divides cofactor row j, component k.
    for (genvar k = 0; k < 3; k++) begin : g_kcol
        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic signed [32:0] num_mag;
            assign num_mag = cof4_reg[j][k][32] ? -cof4_reg[j][k] : cof4_reg[j][k];
            assign lane_in[k * 3 + j].valid = v_reg[3];
            assign lane_in[k * 3 + j].zero  = (det_reg == '0);
            assign lane_in[k * 3 + j].neg   = cof4_reg[j][k][32] ^ det_reg[50];
            assign lane_in[k * 3 + j].num   = num_mag[31:0];
            assign lane_in[k * 3 + j].den   = det_mag[49:0];
            m3inv_div u_div (
                .clk  (clk),
                .rst_n(rst_n),
                .din  (lane_in[k * 3 + j]),
                .dout (lane_out[k * 3 + j])
            );
        end
    end

    // Result beat.
    assign done         = lane_out[0].valid;
    assign inv.out_c0_x = lane_out[0].value;
    assign inv.out_c0_y = lane_out[1].value;
    assign inv.out_c0_z = lane_out[2].value;
    assign inv.out_c1_x = lane_out[3].value;
    assign inv.out_c1_y = lane_out[4].value;
    assign inv.out_c1_z = lane_out[5].value;
    assign inv.out_c2_x = lane_out[6].value;
    assign inv.out_c2_y = lane_out[7].value;
    assign inv.out_c2_z = lane_out[8].value;
    assign inv.singular = lane_out[0].zero;

`include "matrix3_inverse_assert.svh"

    `M3I_ASSERT(a_beat_out, start |-> ##LAT done, "accepted beat produced no result")
    `M3I_ASSERT(a_no_spurious, done |-> $past(start, LAT), "result without accepted beat")
    `M3I_NEVER(a_singular_zero, done && inv.singular && |inv[288:1], "singular beat not zero")

endmodule
`default_nettype wire
